>>> design/keypad_scan_line_buffer_top_macros.svh
// Assertion helpers for the keypad line buffer.
`ifndef KEYPAD_SCAN_LINE_BUFFER_TOP_MACROS_SVH
`define KEYPAD_SCAN_LINE_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define KSLB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define KSLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/kslb_pkg.sv
package kslb_pkg;

    localparam int TABLE_LEN  = 20;
    localparam int FIELD_COLS = 4;
    localparam int IDX_W      = 7;

    localparam logic [7:0] KEY_END   = 8'h45;  // 'E'
    localparam logic [7:0] KEY_CLEAR = 8'h43;  // 'C'

    // first character sits in the top byte
    localparam logic [8*TABLE_LEN-1:0] KEY_TABLE = "P123T456M789BC0EOSLA";

    typedef struct packed {
        logic capture;   // input beat taken
        logic decode;    // evaluate the captured row
        logic append;    // write key into the line store
        logic clear;     // empty the line store
        logic send;      // stream the line out
    } t_cmd;

    typedef struct packed {
        logic key_append;
        logic key_end;
        logic key_clear;
        logic fill_zero;
        logic fill_last;  // an append fills the buffer
        logic send_done;  // terminator loaded
    } t_sts;

    function automatic logic [7:0] key_at(input logic [4:0] idx);
        logic [7:0] res;
        res = KEY_TABLE[(TABLE_LEN - 1 - int'(idx)) * 8 +: 8];
        return res;
    endfunction

endpackage

>>> design/keypad_scan_line_buffer_top.sv
// Keypad scanner with an eight-key line buffer.
// Input channel (i_valid/o_ready): one scanned row per beat, i_row and
// i_col_levels. A column that rose since that row's last scan gives a key
// from the fixed 20-key table; 'C' empties the line, 'E' sends it unless it is empty, other
// keys are appended and a full line is sent at once.
// Output channel (o_valid/i_ready): one byte per beat on o_tx_byte; the
// terminator 'E' closes each sent line with o_last high.
// Timing: a row with no send passes through capture and decode. A send of
// N buffered bytes keeps the input closed until the terminator is loaded:
// after decode the line store is read through its single registered read
// port, one byte per cycle while the receiver keeps up, then the terminator.
// A stalled receiver holds the output register and the send waits with it;
// a finished last byte may wait in the output register while the next row
// is accepted.
// Reset (i_rst_n low, synchronous) clears the row history, empties the line
// and drops o_valid. The line store itself is not cleared.
module keypad_scan_line_buffer_top #(
    parameter int LINE_DEPTH = 8,
    parameter int NUM_ROWS   = 5,
    parameter int NUM_COLS   = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_row,
    input  logic [3:0] i_col_levels,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_last
);
    import kslb_pkg::*;

    t_cmd s_cmd;
    t_sts s_sts;

    kslb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    kslb_dp #(
        .LINE_DEPTH (LINE_DEPTH),
        .NUM_ROWS   (NUM_ROWS),
        .NUM_COLS   (NUM_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_row        (i_row),
        .i_col_levels (i_col_levels),
        .i_cmd        (s_cmd),
        .o_sts        (s_sts),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tx_byte    (o_tx_byte),
        .o_last       (o_last)
    );

`include "keypad_scan_line_buffer_top_macros.svh"

    `KSLB_ASSERT_NOW(a_no_accept_in_send, i_clk, i_rst_n, s_cmd.send, !o_ready, "input open during send")
    `KSLB_ASSERT_NEXT(a_done_loads_term, i_clk, i_rst_n, s_sts.send_done, o_valid && o_last && (o_tx_byte == KEY_END), "terminator not loaded")
    `KSLB_ASSERT_NEXT(a_done_empties, i_clk, i_rst_n, s_sts.send_done, s_sts.fill_zero, "line not emptied after send")

endmodule

>>> design/kslb_ctrl.sv
module kslb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  kslb_pkg::t_sts i_sts,
    output kslb_pkg::t_cmd o_cmd
);
    import kslb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECODE = 3'b010,
        ST_SEND   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.capture = i_valid;
                if (i_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = ST_IDLE;
                if (i_sts.key_end) begin
                    if (!i_sts.fill_zero) begin
                        n_state = ST_SEND;
                    end
                end else if (i_sts.key_clear) begin
                    o_cmd.clear = 1'b1;
                end else if (i_sts.key_append) begin
                    o_cmd.append = 1'b1;
                    if (i_sts.fill_last) begin
                        n_state = ST_SEND;
                    end
                end
            end
            ST_SEND: begin
                o_cmd.send = 1'b1;
                if (i_sts.send_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/kslb_dp.sv
module kslb_dp #(
    parameter int LINE_DEPTH = 8,
    parameter int NUM_ROWS   = 5,
    parameter int NUM_COLS   = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [2:0]     i_row,
    input  logic [3:0]     i_col_levels,
    input  kslb_pkg::t_cmd i_cmd,
    output kslb_pkg::t_sts o_sts,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_tx_byte,
    output logic           o_last
);
    import kslb_pkg::*;

    localparam int USE_COLS = (NUM_COLS < FIELD_COLS) ? NUM_COLS : FIELD_COLS;
    localparam logic [3:0] COL_MASK = 4'((1 << USE_COLS) - 1);
    localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // captured input beat
    logic [2:0] r_row;
    logic [3:0] r_levels;

    logic [3:0] r_prev [NUM_ROWS];
    logic [7:0] r_mem  [LINE_DEPTH];

    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_ptr;
    logic             r_rd_vld;
    logic [7:0]       r_rd_data;
    logic             r_out_vld;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    // decode
    logic             in_range;
    logic [ROW_W-1:0] row_ix;
    logic [3:0]       rose;
    logic [1:0]       col;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic             key_ok;
    logic [7:0]       key;

    // send pipeline
    logic out_free;
    logic take;
    logic issue;
    logic term;

    assign in_range = int'(r_row) < NUM_ROWS;
    assign row_ix   = ROW_W'(r_row);
    assign rose     = in_range ? (r_levels & ~r_prev[row_ix]) : 4'b0000;

    always_comb begin
        col   = 2'd0;
        found = 1'b1;
        priority if (rose[0]) col = 2'd0;
        else if (rose[1]) col = 2'd1;
        else if (rose[2]) col = 2'd2;
        else if (rose[3]) col = 2'd3;
        else found = 1'b0;
    end

    assign idx    = IDX_W'(r_row) * IDX_W'(NUM_COLS) + IDX_W'(col);
    assign key_ok = found && (idx < IDX_W'(TABLE_LEN));
    assign key    = key_at(idx[4:0]);

    assign o_sts.key_end    = key_ok && (key == KEY_END);
    assign o_sts.key_clear  = key_ok && (key == KEY_CLEAR);
    assign o_sts.key_append = key_ok && (key != KEY_END) && (key != KEY_CLEAR);
    assign o_sts.fill_zero  = (r_fill == '0);
    assign o_sts.fill_last  = (r_fill + CNT_W'(1)) == CNT_W'(LINE_DEPTH);
    assign o_sts.send_done  = i_cmd.send && term;

    assign out_free = !r_out_vld || i_ready;
    assign take     = i_cmd.send && r_rd_vld && out_free;
    assign issue    = i_cmd.send && (r_ptr < r_fill) && (!r_rd_vld || take);
    assign term     = !r_rd_vld && (r_ptr == r_fill) && out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row    <= i_row;
            r_levels <= i_col_levels & COL_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ROWS; i++) begin
                r_prev[i] <= 4'b0000;
            end
        end else if (i_cmd.decode && in_range) begin
            r_prev[row_ix] <= r_levels;
        end
    end

    // line store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[r_fill[ADDR_W-1:0]] <= key;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.decode) begin
                r_ptr    <= '0;
                r_rd_vld <= 1'b0;
            end else if (issue) begin
                r_ptr    <= r_ptr + CNT_W'(1);
                r_rd_vld <= 1'b1;
            end else if (take) begin
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.append) begin
                r_fill <= r_fill + CNT_W'(1);
            end else if (i_cmd.clear || o_sts.send_done) begin
                r_fill <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (take || o_sts.send_done) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_byte <= r_rd_data;
            r_out_last <= 1'b0;
        end else if (o_sts.send_done) begin
            r_out_byte <= KEY_END;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_tx_byte = r_out_byte;
    assign o_last    = r_out_last;

endmodule

>>> verif/tb_keypad_scan_line_buffer_top.sv
module tb_keypad_scan_line_buffer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kslb_pkg::*;

    localparam int LINE_DEPTH  = 8;
    localparam int NUM_ROWS    = 5;
    localparam int NUM_COLS    = 4;
    localparam int RAND_ROWS   = 150;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int KEY_POS_END = 15;   // 'E' sits at row 3, column 3

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_tx_beat;

    // directed scan: row, column levels, bytes the scan should send
    typedef struct packed {
        logic [2:0] row;
        logic [3:0] cols;
        logic [3:0] n_tx;
    } t_scan_vec;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [2:0] i_row        = '0;
    logic [3:0] i_col_levels = '0;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_tx_byte;
    logic       o_last;

    // key map: row0 P123, row1 T456, row2 M789, row3 BC0E, row4 OSLA
    t_scan_vec directed_scans [0:21] = '{
        '{3'd0, 4'b0000, 4'd0},   // quiet row right after reset
        '{3'd3, 4'b1000, 4'd0},   // 'E' with an empty line
        '{3'd3, 4'b0000, 4'd0},
        '{3'd0, 4'b1111, 4'd0},   // all columns rise, 'P' wins
        '{3'd7, 4'b1111, 4'd0},   // rows past the keypad are dropped
        '{3'd5, 4'b1111, 4'd0},
        '{3'd1, 4'b0110, 4'd0},   // '4'
        '{3'd3, 4'b1000, 4'd3},   // 'E' sends P 4 E
        '{3'd3, 4'b0000, 4'd0},
        '{3'd2, 4'b1111, 4'd0},   // 'M'
        '{3'd3, 4'b0010, 4'd0},   // 'C' drops the line quietly
        '{3'd3, 4'b1000, 4'd0},   // 'E' after the clear sends nothing
        '{3'd3, 4'b0000, 4'd0},
        '{3'd4, 4'b0001, 4'd0},   // O
        '{3'd4, 4'b0011, 4'd0},   // S
        '{3'd4, 4'b0111, 4'd0},   // L
        '{3'd4, 4'b1111, 4'd0},   // A
        '{3'd1, 4'b1000, 4'd0},   // 6
        '{3'd3, 4'b0001, 4'd0},   // B
        '{3'd3, 4'b0101, 4'd0},   // 0
        '{3'd1, 4'b1001, 4'd9},   // T fills the line: eight keys plus terminator
        '{3'd6, 4'b0000, 4'd0}
    };

    logic [3:0] row_levels [NUM_ROWS] = '{default: '0};
    logic [7:0] key_line [$];
    t_tx_beat   pending_tx [$];

    int  mismatches   = 0;
    int  stall_cycles = 0;
    int  rows_in      = 0;
    int  rx_beats     = 0;
    int  rx_lines     = 0;
    bit  no_idle      = 1'b0;

    keypad_scan_line_buffer_top #(
        .LINE_DEPTH(LINE_DEPTH),
        .NUM_ROWS  (NUM_ROWS),
        .NUM_COLS  (NUM_COLS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_row       (i_row),
        .i_col_levels(i_col_levels),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    // queue the buffered keys and the terminator, then empty the line
    function automatic int send_line();
        int n;
        n = key_line.size();
        if (n == 0)
            return 0;
        foreach (key_line[i])
            pending_tx.push_back('{ch: key_line[i], last: 1'b0});
        pending_tx.push_back('{ch: KEY_END, last: 1'b1});
        key_line.delete();
        return n + 1;
    endfunction

    function automatic int decode_scan(input logic [2:0] r, input logic [3:0] lv);
        logic [3:0] rose;
        logic [7:0] key;
        int         col;
        int         pos;
        int         i;
        col = -1;
        if (int'(r) >= NUM_ROWS)
            return 0;
        rose = lv & ~row_levels[r];
        row_levels[r] = lv;
        for (i = FIELD_COLS - 1; i >= 0; i--)
            if (rose[i])
                col = i;
        if (col < 0)
            return 0;
        pos = int'(r) * NUM_COLS + col;
        if (pos >= TABLE_LEN)
            return 0;
        key = KEY_TABLE[(TABLE_LEN - 1 - pos) * 8 +: 8];
        if (key == KEY_END)
            return send_line();
        if (key == KEY_CLEAR) begin
            key_line.delete();
            return 0;
        end
        key_line.push_back(key);
        if (key_line.size() >= LINE_DEPTH)
            return send_line();
        return 0;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic drive_row(input logic [2:0] r, input logic [3:0] lv, input int gap,
                             output int n_tx);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_row        <= r;
        i_col_levels <= lv;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        n_tx = decode_scan(r, lv);
        rows_in++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_tx_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            rx_beats++;
            if (o_last)
                rx_lines++;
            if (pending_tx.size() == 0) begin
                flag_mismatch($sformatf("byte 0x%02h last=%0b with nothing pending",
                                        o_tx_byte, o_last));
            end else begin
                want = pending_tx.pop_front();
                if (o_tx_byte !== want.ch)
                    flag_mismatch($sformatf("tx_byte 0x%02h, want 0x%02h",
                                            o_tx_byte, want.ch));
                if (o_last !== want.last)
                    flag_mismatch($sformatf("last %0b on byte 0x%02h, want %0b",
                                            o_last, o_tx_byte, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no beat in either direction for %0d cycles", STALL_LIMIT);
            $display("keypad_scan_line_buffer_top test failed");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold once bytes are flowing
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = pick_gap();
            if (!held && rx_beats >= 20) begin
                gap  = LONG_HOLD;
                held = 1'b1;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid)
                @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        int         n_tx;
        int         kidx;
        int         col;
        int         mode;
        int         live_rows;
        logic [2:0] r;
        logic [3:0] lv;
        logic [3:0] up_mask;
        bit         drained;
        live_rows = 0;
        drained   = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_scans[i]) begin
            drive_row(directed_scans[i].row, directed_scans[i].cols, pick_gap(), n_tx);
            if (n_tx != int'(directed_scans[i].n_tx))
                flag_mismatch($sformatf("directed scan %0d predicts %0d bytes, table says %0d",
                                        i, n_tx, directed_scans[i].n_tx));
        end

        while (live_rows < RAND_ROWS) begin
            no_idle = (live_rows >= 40 && live_rows < 70);
            if (!drained && live_rows >= 100) begin
                // let the output run dry before going on
                drained = 1'b1;
                i_valid <= 1'b0;
                while (pending_tx.size() != 0)
                    @(posedge i_clk);
                @(negedge i_clk);
            end
            mode = $urandom_range(0, 9);
            if (mode < 7) begin
                // clean keypress: release the column, then raise it
                kidx = ($urandom_range(0, 5) == 0) ? KEY_POS_END : $urandom_range(0, 19);
                r    = 3'(kidx / NUM_COLS);
                col  = kidx % NUM_COLS;
                lv   = row_levels[r] & ~(4'b0001 << col);
                drive_row(r, lv, pick_gap(), n_tx);
                up_mask = 4'hF << (col + 1);
                lv = lv | (4'b0001 << col) | (4'($urandom_range(0, 15)) & up_mask);
                drive_row(r, lv, pick_gap(), n_tx);
                live_rows += 2;
            end else if (mode < 9) begin
                drive_row(3'($urandom_range(0, NUM_ROWS - 1)), 4'($urandom_range(0, 15)),
                          pick_gap(), n_tx);
                live_rows++;
            end else begin
                drive_row(3'($urandom_range(NUM_ROWS, 7)), 4'($urandom_range(0, 15)),
                          pick_gap(), n_tx);
            end
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        while (pending_tx.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d scan rows taken (%0d directed), %0d bytes checked in %0d sent lines",
                 rows_in, $size(directed_scans), rx_beats, rx_lines);
        $display("run had a %0d-cycle receiver hold, a drain pause and a no-gap stretch",
                 LONG_HOLD);
        if (mismatches == 0)
            $display("keypad_scan_line_buffer_top test passed");
        else
            $display("keypad_scan_line_buffer_top test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/kslb_pkg.sv
design/kslb_ctrl.sv
design/kslb_dp.sv
design/keypad_scan_line_buffer_top.sv
verif/tb_keypad_scan_line_buffer_top.sv
